>>> src/rtd_cvd_pkg.sv
// ----------------------------------------------------------------------------
// rtd_cvd_pkg
// Shared widths, constants, tables and types for the RTD temperature converter.
// ----------------------------------------------------------------------------
package rtd_cvd_pkg;

  localparam int CodeW  = 15;
  localparam int IdxW   = 5;
  localparam int RrefW  = 13;
  localparam int RqW    = 31;          // resistance, unsigned Q13.18 ohms
  localparam int KW     = 22;
  localparam int KrW    = RqW + KW;
  localparam int GW     = 49;          // root argument when it is not negative
  localparam int RW     = 17;          // normalized resistance, Q10
  localparam int RootW  = 29;
  localparam int VW     = 2 * RootW;   // radicand
  localparam int RemW   = 33;
  localparam int PW     = 56;          // Horner accumulator, Q40
  localparam int TW     = 17;          // unsaturated polynomial result
  localparam int OutW   = 15;
  localparam int DataW  = 32;
  localparam int AddrW  = 3;

  localparam int QueueDepthDefault = 4;

  localparam logic [IdxW-1:0] RrefIndexReset = 5'd28;

  localparam logic [GW-1:0]    GBase     = GW'(64'd1758480889 << 18);
  localparam logic [KW-1:0]    K100      = 22'd2310000;
  localparam logic [KW-1:0]    K1000     = 22'd231000;
  localparam logic [RootW-1:0] ACoef     = RootW'(64'd39083 << 13);
  localparam logic [23:0]      Recip5    = 24'd13421773;   // ceil(2^26 / 5)
  localparam logic [24:0]      Recip231  = 25'd18592933;   // ceil(2^32 / 231)
  localparam int               RMax      = 131071;
  localparam int               T10Max    = 8500;
  localparam int               T10Min    = -2500;
  localparam int               HornerSteps = 5;

  // Polynomial coefficients times ten, in Q40, truncated toward zero.
  localparam logic signed [63:0] PC0 = -((64'sd242020 <<< 40) / 64'sd100);
  localparam logic signed [63:0] PC1 = (64'sd22228 <<< 40) / 64'sd1000;
  localparam logic signed [63:0] PC2 = (64'sd25859 <<< 40) / 64'sd1000000;
  localparam logic signed [63:0] PC3 = -((64'sd4826 <<< 40) / 64'sd100000000);
  localparam logic signed [63:0] PC4 = -((64'sd28183 <<< 40) / 64'sd100000000000);
  localparam logic signed [63:0] PC5 = (64'sd15243 <<< 40) / 64'sd10000000000000;

  typedef enum logic [0:0] {
    RegRrefIndex     = 1'b0,
    RegNominalSelect = 1'b1
  } cfg_reg_t;

  // One classified sample on its way from the front end to the back end.
  typedef struct packed {
    logic            root_neg;
    logic [GW-1:0]   g;
    logic [RW-1:0]   r;
  } rtd_cvd_item_t;

  function automatic logic [RrefW-1:0] rref_ohms(input logic [IdxW-1:0] idx);
    logic [RrefW-1:0] v;
    case (idx)
      5'd0:  v = 13'd430;
      5'd1:  v = 13'd432;
      5'd2:  v = 13'd442;
      5'd3:  v = 13'd470;
      5'd4:  v = 13'd499;
      5'd5:  v = 13'd510;
      5'd6:  v = 13'd560;
      5'd7:  v = 13'd620;
      5'd8:  v = 13'd680;
      5'd9:  v = 13'd768;
      5'd10: v = 13'd1000;
      5'd11: v = 13'd1100;
      5'd12: v = 13'd1200;
      5'd13: v = 13'd1300;
      5'd14: v = 13'd1400;
      5'd15: v = 13'd1500;
      5'd16: v = 13'd1600;
      5'd17: v = 13'd1740;
      5'd18: v = 13'd1800;
      5'd19: v = 13'd1910;
      5'd20: v = 13'd2000;
      5'd21: v = 13'd2100;
      5'd22: v = 13'd2400;
      5'd23: v = 13'd2700;
      5'd24: v = 13'd3000;
      5'd25: v = 13'd3090;
      5'd26: v = 13'd3400;
      5'd27: v = 13'd3900;
      5'd28: v = 13'd4300;
      5'd29: v = 13'd4700;
      5'd30: v = 13'd4990;
      5'd31: v = 13'd5600;
      default: v = 13'd430;
    endcase
    return v;
  endfunction

  // Coefficient added after Horner step number 'step' (highest order first).
  function automatic logic signed [PW-1:0] horner_coef(input logic [2:0] step);
    logic signed [PW-1:0] c;
    case (step)
      3'd0:    c = PW'(PC4);
      3'd1:    c = PW'(PC3);
      3'd2:    c = PW'(PC2);
      3'd3:    c = PW'(PC1);
      3'd4:    c = PW'(PC0);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> src/rtd_cvd_front.sv
// ----------------------------------------------------------------------------
// rtd_cvd_front
// Accepts codes, forms resistance, root argument and normalized resistance.
// ----------------------------------------------------------------------------
module rtd_cvd_front
  import rtd_cvd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                code_valid,
  output logic                code_ready,
  input  logic [CodeW-1:0]    raw_code,
  input  logic [IdxW-1:0]     rref_index,
  input  logic                nominal_select,
  output logic                push,
  output rtd_cvd_item_t       push_item,
  input  logic                full
);

  logic                en;
  logic                v1, v2, v3;
  logic [RqW-1:0]      rq1;
  logic [KrW-1:0]      kr2;
  logic [45:0]         rdiv2;
  logic [RqW-9:0]      rq2_hi;
  logic                nom2;
  logic [KW-1:0]       k_sel;
  logic [27:0]         prod1;
  logic                neg;
  logic [RqW-9:0]      rsel;
  logic [RW-1:0]       r_lim;
  rtd_cvd_item_t       item3;

  assign en         = !v3 || !full;
  assign code_ready = en;
  assign push       = v3 && !full;
  assign push_item  = item3;

  assign prod1 = 28'(raw_code) * 28'(rref_ohms(rref_index));
  assign k_sel = nominal_select ? K1000 : K100;

  assign neg   = kr2 > KrW'(GBase);
  assign rsel  = nom2 ? (RqW-8)'(rdiv2[45:26]) : rq2_hi;
  assign r_lim = (rsel > (RqW-8)'(RMax)) ? RW'(RMax) : rsel[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= code_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rq1            <= {prod1, 3'b000};
      kr2            <= KrW'(rq1) * KrW'(k_sel);
      rdiv2          <= 46'(rq1[RqW-1:9]) * 46'(Recip5);
      rq2_hi         <= rq1[RqW-1:8];
      nom2           <= nominal_select;
      item3.root_neg <= neg;
      item3.g        <= neg ? '0 : GBase - kr2[GW-1:0];
      item3.r        <= r_lim;
    end
  end

endmodule

>>> src/rtd_cvd_queue.sv
// ----------------------------------------------------------------------------
// rtd_cvd_queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rtd_cvd_queue
  import rtd_cvd_pkg::*;
#(
  parameter int DEPTH = QueueDepthDefault
)(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rtd_cvd_item_t push_item,
  output logic          full,
  input  logic          pop,
  output rtd_cvd_item_t pop_item,
  output logic          empty
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  rtd_cvd_item_t   mem [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full     = count == CntW'(DEPTH);
  assign empty    = count == '0;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> src/rtd_cvd_isqrt.sv
// ----------------------------------------------------------------------------
// rtd_cvd_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rtd_cvd_isqrt
  import rtd_cvd_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [VW-1:0]    radicand,
  output logic [RootW-1:0] root
);

  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [VW-1:0]    rad_q  [RootW];

  for (genvar i = 0; i < RootW; i++) begin : g_stage
    logic [RemW-1:0]  rem_in, rem_sh, trial;
    logic [RootW-1:0] root_in;
    logic [VW-1:0]    rad_in;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    // Bring down the next two radicand bits and try a one in this position.
    assign rem_sh = {rem_in[RemW-3:0], rad_in[VW-1-2*i -: 2]};
    assign trial  = RemW'({root_in, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? rem_sh - trial : rem_sh;
        root_q[i] <= {root_in[RootW-2:0], ge};
        rad_q[i]  <= rad_in;
      end
    end
  end

  assign root = root_q[RootW-1];

endmodule

>>> src/rtd_cvd_horner.sv
// ----------------------------------------------------------------------------
// rtd_cvd_horner
// Pipelined fifth-order Horner evaluation, two stages per step.
// ----------------------------------------------------------------------------
module rtd_cvd_horner
  import rtd_cvd_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [RW-1:0]        r,
  output logic signed [TW-1:0] t10
);

  localparam int SplitW = 26;
  localparam int HiW    = PW - SplitW;
  localparam int PhW    = HiW + RW + 1;
  localparam int PlW    = SplitW + RW;
  localparam int FullW  = PhW + SplitW;

  logic signed [PhW-1:0] prh_q [HornerSteps];
  logic [PlW-1:0]        prl_q [HornerSteps];
  logic [RW-1:0]         ra_q  [HornerSteps];
  logic signed [PW-1:0]  p_q   [HornerSteps];
  logic [RW-1:0]         rb_q  [HornerSteps];

  for (genvar j = 0; j < HornerSteps; j++) begin : g_step
    logic signed [PW-1:0]    p_in;
    logic [RW-1:0]           r_in;
    logic signed [PhW-1:0]   ph_ext, r_ext;
    logic signed [FullW-1:0] full_sum, shifted;

    if (j == 0) begin : g_first
      assign p_in = PW'(PC5);
      assign r_in = r;
    end else begin : g_next
      assign p_in = p_q[j-1];
      assign r_in = rb_q[j-1];
    end

    // The wide product is built from a signed high half and unsigned low half.
    assign ph_ext   = PhW'($signed(p_in[PW-1:SplitW]));
    assign r_ext    = $signed(PhW'(r_in));
    assign full_sum = $signed({prh_q[j], {SplitW{1'b0}}}) + $signed(FullW'(prl_q[j]));
    assign shifted  = full_sum >>> 10;

    always_ff @(posedge clk) begin
      if (en) begin
        prh_q[j] <= ph_ext * r_ext;
        prl_q[j] <= PlW'(p_in[SplitW-1:0]) * PlW'(r_in);
        ra_q[j]  <= r_in;
        p_q[j]   <= shifted[PW-1:0] + horner_coef(3'(j));
        rb_q[j]  <= ra_q[j];
      end
    end
  end

  logic signed [PW-1:0] p_fin, p_mag;
  assign p_fin = p_q[HornerSteps-1];
  assign p_mag = -p_fin;

  // Truncate toward zero when dropping the forty fraction bits.
  always_ff @(posedge clk) begin
    if (en) begin
      if (!p_fin[PW-1]) begin
        t10 <= $signed({1'b0, p_fin[PW-1:40]});
      end else begin
        t10 <= -$signed({1'b0, p_mag[PW-1:40]});
      end
    end
  end

endmodule

>>> src/rtd_cvd_back.sv
// ----------------------------------------------------------------------------
// rtd_cvd_back
// Solves for temperature from a classified sample and drives the result port.
// ----------------------------------------------------------------------------
module rtd_cvd_back
  import rtd_cvd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  output logic                   pop,
  input  rtd_cvd_item_t          pop_item,
  input  logic                   empty,
  output logic                   temp_valid,
  input  logic                   temp_ready,
  output logic signed [OutW-1:0] temperature_tenths,
  output logic                   used_low_polynomial,
  output logic                   out_of_range
);

  localparam int SqLat   = RootW;
  localparam int HLat    = 2 * HornerSteps + 1;
  localparam int PolyDly = SqLat + 2 - HLat;

  localparam logic signed [TW-1:0] PMax = TW'(T10Max);
  localparam logic signed [TW-1:0] PMin = TW'(T10Min);

  logic                 en;
  logic                 sh_v   [SqLat];
  logic                 sh_neg [SqLat];
  logic [RootW-1:0]     root;
  logic signed [TW-1:0] t_poly;
  logic signed [TW-1:0] pdl [PolyDly];

  logic                 va, nega, nnega;
  logic [22:0]          ma;
  logic                 vb, negb, nnegb;
  logic [15:0]          qb;

  logic [RootW-1:0]     nmag;
  logic [33:0]          n25;
  logic [47:0]          qprod;

  logic signed [TW-1:0] t_sel;
  logic                 low_sel, oor_sel;

  assign en  = !temp_valid || temp_ready;
  assign pop = en && !empty;

  rtd_cvd_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand ({1'b0, pop_item.g, 8'b0}),
    .root     (root)
  );

  rtd_cvd_horner u_horner (
    .clk (clk),
    .en  (en),
    .r   (pop_item.r),
    .t10 (t_poly)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SqLat; i++) begin
        sh_v[i] <= 1'b0;
      end
      va         <= 1'b0;
      vb         <= 1'b0;
      temp_valid <= 1'b0;
    end else if (en) begin
      sh_v[0] <= !empty;
      for (int i = 1; i < SqLat; i++) begin
        sh_v[i] <= sh_v[i-1];
      end
      va         <= sh_v[SqLat-1];
      vb         <= va;
      temp_valid <= vb;
    end
  end

  assign nmag  = ACoef - root;
  assign n25   = 34'(nmag) * 34'd25;
  assign qprod = 48'(ma) * 48'(Recip231);

  always_ff @(posedge clk) begin
    if (en) begin
      sh_neg[0] <= pop_item.root_neg;
      for (int i = 1; i < SqLat; i++) begin
        sh_neg[i] <= sh_neg[i-1];
      end
      pdl[0] <= t_poly;
      for (int i = 1; i < PolyDly; i++) begin
        pdl[i] <= pdl[i-1];
      end
      nega  <= sh_neg[SqLat-1];
      nnega <= root > ACoef;
      ma    <= n25[32:10];
      negb  <= nega;
      nnegb <= nnega;
      qb    <= qprod[47:32];
    end
  end

  always_comb begin
    t_sel   = '0;
    low_sel = 1'b0;
    oor_sel = 1'b0;
    if (negb) begin
      t_sel   = PMax;
      oor_sel = 1'b1;
    end else if (!nnegb) begin
      if (qb > 16'(T10Max)) begin
        t_sel   = PMax;
        oor_sel = 1'b1;
      end else begin
        t_sel = $signed(TW'(qb));
      end
    end else begin
      low_sel = 1'b1;
      t_sel   = pdl[PolyDly-1];
      if (pdl[PolyDly-1] > PMax) begin
        t_sel   = PMax;
        oor_sel = 1'b1;
      end else if (pdl[PolyDly-1] < PMin) begin
        t_sel   = PMin;
        oor_sel = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temperature_tenths  <= t_sel[OutW-1:0];
      used_low_polynomial <= low_sel;
      out_of_range        <= oor_sel;
    end
  end

endmodule

>>> src/rtd_callendar_van_dusen_temp.sv
// ----------------------------------------------------------------------------
// rtd_callendar_van_dusen_temp
// Platinum RTD ratio code to temperature in tenths of a degree Celsius.
// ----------------------------------------------------------------------------
// The block takes one 15-bit converter ratio code per transfer and returns one
// temperature per code, in the order the codes arrived. Resistance is formed
// as code/32768 times the reference resistor picked by rref_index, and the
// Callendar-Van Dusen quadratic is solved with a pipelined integer square
// root. When that solution is below zero, a fifth-order polynomial in the
// resistance normalized to 100 ohm gives the temperature instead, and
// used_low_polynomial is set. Results are truncated toward zero and held to
// -250.0 .. 850.0 degrees; out_of_range marks a clipped result or a negative
// root argument (which reads as 850.0). The block accepts one code per clock
// cycle and stays at that rate as long as results are taken. Inside, a code
// passes three front-end stages that compute resistance and classify the
// sample, a four-entry queue, and 32 back-end stages, most of them the 29
// stages of the square-root pipeline.
// The queue lets the front end keep taking codes while a stalled result port
// holds the back end. Configuration registers sit on a small APB port:
// rref_index at byte address 0, nominal_select at byte address 4; write them
// only while no transfer is in flight.
// ----------------------------------------------------------------------------
module rtd_callendar_van_dusen_temp
  import rtd_cvd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault
)(
  input  logic                   clk,
  input  logic                   rst,
  // Code input channel.
  input  logic                   code_valid,
  output logic                   code_ready,
  input  logic [CodeW-1:0]       raw_code,
  // Temperature result channel.
  output logic                   temp_valid,
  input  logic                   temp_ready,
  output logic signed [OutW-1:0] temperature_tenths,
  output logic                   used_low_polynomial,
  output logic                   out_of_range,
  // Configuration port.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [AddrW-1:0]       paddr,
  input  logic [DataW-1:0]       pwdata,
  output logic [DataW-1:0]       prdata,
  output logic                   pready
);

  logic [IdxW-1:0] rref_index;
  logic            nominal_select;
  logic            push, full, pop, empty;
  rtd_cvd_item_t   push_item, pop_item;
  cfg_reg_t        reg_sel;

  // The register is picked by the word address; the byte offset is ignored.
  assign reg_sel = cfg_reg_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rref_index     <= RrefIndexReset;
      nominal_select <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        RegRrefIndex:     rref_index     <= pwdata[IdxW-1:0];
        RegNominalSelect: nominal_select <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegRrefIndex:     prdata = DataW'(rref_index);
      RegNominalSelect: prdata = DataW'(nominal_select);
      default:          prdata = '0;
    endcase
  end

  // Front end: resistance, root argument, normalized resistance.
  rtd_cvd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .code_valid     (code_valid),
    .code_ready     (code_ready),
    .raw_code       (raw_code),
    .rref_index     (rref_index),
    .nominal_select (nominal_select),
    .push           (push),
    .push_item      (push_item),
    .full           (full)
  );

  // The queue decouples the two halves so each can stall on its own.
  rtd_cvd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  // Back end: square root, division, polynomial, selection and saturation.
  rtd_cvd_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .pop                 (pop),
    .pop_item            (pop_item),
    .empty               (empty),
    .temp_valid          (temp_valid),
    .temp_ready          (temp_ready),
    .temperature_tenths  (temperature_tenths),
    .used_low_polynomial (used_low_polynomial),
    .out_of_range        (out_of_range)
  );

endmodule

>>> src/rtd_cvd_checker.sv
// ----------------------------------------------------------------------------
// rtd_cvd_checker
// Port-level checks on the RTD temperature converter, bound to its top level.
// ----------------------------------------------------------------------------
module rtd_cvd_checker
  import rtd_cvd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   code_ready,
  input logic                   temp_valid,
  input logic                   temp_ready,
  input logic signed [OutW-1:0] temperature_tenths,
  input logic                   used_low_polynomial,
  input logic                   out_of_range
);

  localparam logic signed [OutW-1:0] OMax = OutW'(T10Max);
  localparam logic signed [OutW-1:0] OMin = OutW'(T10Min);

  // A result that is not taken stays on the port unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    temp_valid && !temp_ready |=> temp_valid && $stable(temperature_tenths)
      && $stable(used_low_polynomial) && $stable(out_of_range))
    else $error("result changed while stalled");

  // Every result lies within the saturation bounds.
  a_range: assert property (@(posedge clk) disable iff (rst)
    temp_valid |-> temperature_tenths <= OMax && temperature_tenths >= OMin)
    else $error("temperature outside bounds");

  // A flagged result from the quadratic is always the upper bound.
  a_flag_quad: assert property (@(posedge clk) disable iff (rst)
    temp_valid && out_of_range && !used_low_polynomial |-> temperature_tenths == OMax)
    else $error("flagged quadratic result not at upper bound");

  // Reset empties the result port and opens the input.
  a_reset: assert property (@(posedge clk)
    rst |=> !temp_valid && code_ready)
    else $error("reset did not clear the pipeline");

endmodule

bind rtd_callendar_van_dusen_temp rtd_cvd_checker u_rtd_cvd_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTD temperature converter testbench
// Drives converter ratio codes through the code channel under several
// reference resistor and nominal resistance settings, predicts temperatures in
// fixed point and compares each result transfer in order.
// ----------------------------------------------------------------------------
module testbench;
  import rtd_cvd_pkg::*;

  localparam int CycleLimit = 400000;

  logic                   clk;
  logic                   rst;
  logic                   code_valid;
  logic                   code_ready;
  logic [CodeW-1:0]       raw_code;
  logic                   temp_valid;
  logic                   temp_ready;
  logic signed [OutW-1:0] temperature_tenths;
  logic                   used_low_polynomial;
  logic                   out_of_range;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [AddrW-1:0]       paddr;
  logic [DataW-1:0]       pwdata;
  logic [DataW-1:0]       prdata;
  logic                   pready;

  rtd_callendar_van_dusen_temp dut (.*);

  // One expected temperature, as it should appear on the result port.
  typedef struct packed {
    logic signed [OutW-1:0] tenths;
    logic                   low_poly;
    logic                   clipped;
  } temp_result_t;

  // A directed row: a code, and optionally a result read straight off the
  // conversion rules. Rows with has_result clear go to the predictor.
  typedef struct {
    logic [CodeW-1:0] code;
    bit               has_result;
    temp_result_t     result;
  } code_row_t;

  temp_result_t pending_temps[$];
  int           error_count;
  int           cycle_count;
  bit           idle_free;     // when set, neither side inserts gaps
  bit           hold_results;  // when set, the result side stalls for a long stretch
  bit           stimulus_done;

  // Shadow copy of the configuration registers.
  logic [IdxW-1:0] shadow_rref_index;
  logic            shadow_nominal;

  // The clock runs from time zero.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run ends with a failure if it ever passes the cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Reference resistor in ohms for a table index.
  function automatic longint rref_of(input logic [IdxW-1:0] idx);
    longint ohms[32] = '{430, 432, 442, 470, 499, 510, 560, 620, 680, 768, 1000,
                         1100, 1200, 1300, 1400, 1500, 1600, 1740, 1800, 1910,
                         2000, 2100, 2400, 2700, 3000, 3090, 3400, 3900, 4300,
                         4700, 4990, 5600};
    return ohms[idx];
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Arithmetic shift right is a floor division by a power of two.
  function automatic longint floor_div1024(input longint v);
    return v >>> 10;
  endfunction

  // Predicts the temperature for one code under the current shadow settings.
  function automatic temp_result_t predict_temperature(input logic [CodeW-1:0] code);
    longint          c[6];
    longint          rq, r0, k, g, n, r, p, t10;
    longint unsigned s;
    temp_result_t    res;
    c[0] = -((64'sd242020 <<< 40) / 64'sd100);
    c[1] = (64'sd22228 <<< 40) / 64'sd1000;
    c[2] = (64'sd25859 <<< 40) / 64'sd1000000;
    c[3] = -((64'sd4826 <<< 40) / 64'sd100000000);
    c[4] = -((64'sd28183 <<< 40) / 64'sd100000000000);
    c[5] = (64'sd15243 <<< 40) / 64'sd10000000000000;
    rq = longint'(code) * rref_of(shadow_rref_index) * 8;
    r0 = shadow_nominal ? 1000 : 100;
    k  = shadow_nominal ? 231000 : 2310000;
    g  = (64'sd1758480889 <<< 18) - k * rq;
    res.low_poly = 1'b0;
    res.clipped  = 1'b0;
    if (g < 0) begin
      // A negative root argument reads as the top of the range.
      t10 = 8500;
      res.clipped = 1'b1;
    end else begin
      s = int_sqrt(longint'(g) << 8);
      n = (64'sd39083 <<< 13) - longint'(s);
      if (n >= 0) begin
        t10 = (n * 200) / (64'sd231 <<< 13);
      end else begin
        // Below zero the fifth-order polynomial takes over.
        r = (rq * 100) / (r0 * 256);
        if (r > 131071) r = 131071;
        p = c[5];
        for (int i = 4; i >= 0; i--) p = floor_div1024(p * r) + c[i];
        if (p >= 0) t10 = p >>> 40;
        else t10 = -((-p) >>> 40);
        res.low_poly = 1'b1;
      end
      if (t10 > 8500) begin
        t10 = 8500;
        res.clipped = 1'b1;
      end
      if (t10 < -2500) begin
        t10 = -2500;
        res.clipped = 1'b1;
      end
    end
    res.tenths = OutW'(t10);
    return res;
  endfunction

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic write_register(input cfg_reg_t which, input logic [DataW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * int'(which));
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (which == RegRrefIndex) shadow_rref_index = value[IdxW-1:0];
    else shadow_nominal = value[0];
  endtask

  // Sends one code, holding valid until the transfer completes. Valid stays
  // high afterwards so the next code can follow at once; a gap or the end of
  // a batch drops it. Expectations are queued at the accepting edge.
  task automatic send_code(input logic [CodeW-1:0] code, input bit has_result,
                           input temp_result_t fixed_result);
    temp_result_t exp_res;
    exp_res = has_result ? fixed_result : predict_temperature(code);
    if (!idle_free) begin
      while ($urandom_range(99) < 20) begin
        code_valid <= 1'b0;
        @(negedge clk);
      end
    end
    code_valid <= 1'b1;
    raw_code   <= code;
    @(posedge clk);
    while (!code_ready) @(posedge clk);
    pending_temps.push_back(exp_res);
    @(negedge clk);
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic drain_results();
    code_valid <= 1'b0;
    while (pending_temps.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  // Result side: random stalls, except when gaps are switched off or during
  // the long hold-off that makes the input queue fill.
  always @(negedge clk) begin
    if (rst) begin
      temp_ready <= 1'b0;
    end else if (hold_results) begin
      temp_ready <= 1'b0;
    end else if (idle_free || stimulus_done) begin
      temp_ready <= 1'b1;
    end else begin
      temp_ready <= ($urandom_range(99) >= 20);
    end
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    temp_result_t want;
    if (!rst && temp_valid && temp_ready) begin
      if (pending_temps.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", temperature_tenths));
      end else begin
        want = pending_temps.pop_front();
        if (temperature_tenths !== want.tenths)
          report_mismatch($sformatf("temperature %0d, want %0d",
                                    temperature_tenths, want.tenths));
        if (used_low_polynomial !== want.low_poly)
          report_mismatch($sformatf("low polynomial flag %b, want %b",
                                    used_low_polynomial, want.low_poly));
        if (out_of_range !== want.clipped)
          report_mismatch($sformatf("range flag %b, want %b",
                                    out_of_range, want.clipped));
      end
    end
  end

  // Long stall on the result side, counted in cycles, while codes keep coming.
  task automatic hold_off_results(input int cycles);
    hold_results = 1'b1;
    repeat (cycles) @(negedge clk);
    hold_results = 1'b0;
  endtask

  // Sends a batch of random codes; most are spread over the whole range, some
  // are at the edges of the code field.
  task automatic send_random_codes(input int count);
    logic [CodeW-1:0] code;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       code = CodeW'($urandom_range(15));
        1:       code = CodeW'(32767 - $urandom_range(15));
        default: code = CodeW'($urandom);
      endcase
      send_code(code, 1'b0, '0);
    end
  endtask

  code_row_t directed_rows[$];
  temp_result_t none;

  initial begin
    // Settings for the random phases; the extremes of both registers appear.
    logic [IdxW-1:0] phase_rref[8] = '{5'd28, 5'd0, 5'd31, 5'd10, 5'd4, 5'd22, 5'd31, 5'd0};
    logic            phase_nom[8]  = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    rst           = 1'b1;
    code_valid    = 1'b0;
    raw_code      = '0;
    temp_ready    = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    error_count   = 0;
    cycle_count   = 0;
    idle_free     = 1'b0;
    hold_results  = 1'b0;
    stimulus_done = 1'b0;
    none          = '0;
    shadow_rref_index = RrefIndexReset;
    shadow_nominal    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset settings (4300 ohm reference, 100 ohm
    // sensor). A zero code is zero ohms, which the polynomial puts at its
    // constant term, -242.0 degrees; the full code is about 4300 ohm, which
    // makes the root argument negative.
    directed_rows.push_back('{15'd0, 1'b1, '{-15'sd2420, 1'b1, 1'b0}});
    directed_rows.push_back('{15'd32767, 1'b1, '{15'sd8500, 1'b0, 1'b1}});
    directed_rows.push_back('{15'd1, 1'b0, none});
    directed_rows.push_back('{15'd762, 1'b0, none});   // about 100 ohm, near zero
    directed_rows.push_back('{15'd761, 1'b0, none});
    directed_rows.push_back('{15'd763, 1'b0, none});
    directed_rows.push_back('{15'd500, 1'b0, none});
    directed_rows.push_back('{15'd2980, 1'b0, none});  // near the top of the range
    directed_rows.push_back('{15'd3500, 1'b0, none});
    directed_rows.push_back('{15'd16384, 1'b0, none});
    directed_rows.push_back('{15'h5555, 1'b0, none});
    directed_rows.push_back('{15'h2AAA, 1'b0, none});
    foreach (directed_rows[i])
      send_code(directed_rows[i].code, directed_rows[i].has_result,
                directed_rows[i].result);
    drain_results();

    // Random phases; the second runs with no gaps at all, one includes a long
    // hold-off on the result side.
    for (int ph = 0; ph < 8; ph++) begin
      write_register(RegRrefIndex, DataW'(phase_rref[ph]));
      write_register(RegNominalSelect, DataW'(phase_nom[ph]));
      idle_free = (ph == 1);
      if (ph == 2) begin
        fork
          hold_off_results(200);
          send_random_codes(236);
        join
      end else begin
        send_random_codes(236);
      end
      drain_results();
    end

    stimulus_done = 1'b1;
    drain_results();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
